### src/height_map_text_parser_macros.svh
// ----------------------------------------------------------------------------
// Height map text parser assertion macros
// Shared property wrappers for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_MAP_TEXT_PARSER_MACROS_SVH
`define HEIGHT_MAP_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HMTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HMTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/hmtp_pkg.sv
// ----------------------------------------------------------------------------
// Height map text parser package
// Field widths, map limits, result kinds and the queue entry type.
// ----------------------------------------------------------------------------
package hmtp_pkg;

  localparam int HMTP_VAL_W    = 32;
  localparam int HMTP_COL_W    = 11;
  localparam int HMTP_ROW_W    = 10;
  localparam int HMTP_MAX_COLS = 1024;
  localparam int HMTP_MAX_ROWS = 1024;
  localparam int HMTP_QDEPTH   = 4;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_ROW_END = 1'b1;

  typedef struct packed {
    logic                  fld_v;
    logic                  end_v;
    logic [HMTP_VAL_W-1:0] value;
    logic [HMTP_COL_W-1:0] fld_col;
    logic [HMTP_COL_W-1:0] end_col;
    logic [HMTP_ROW_W-1:0] row;
    logic                  first;
  } hmtp_entry_t;

endpackage

### src/height_map_text_parser.sv
// ----------------------------------------------------------------------------
// Height map text parser
// Streaming parser of a space/newline separated signed decimal height map.
// ----------------------------------------------------------------------------
// Input channel: one text byte per beat on in_text_byte, with in_stream_end
// marking the last byte of the map text. Output channel: one result per beat,
// either a field (out_kind 0, value, column, row) or a row end (out_kind 1,
// value 0, out_column holding the row's field count).
// Throughput: one byte per cycle while the queue has room. A byte that closes
// a field and ends a row yields two result beats; these drain one per cycle,
// unless the receiver stalls, from a QDEPTH-entry queue between the byte
// parser and the output stage, so the output port rate of one beat per cycle
// sets the sustained figure. A result is written to the queue when its byte
// is accepted, then loaded into the output register.
// Reset: all parse state and the queue clear; the next byte starts a new map.
// Stream end also returns the parse state to its reset values.
// Receiver stall: the output register holds its beat; the queue keeps
// filling and in_ready drops once it is full, resuming as beats drain.
// ----------------------------------------------------------------------------
module height_map_text_parser #(
  parameter int QDEPTH = hmtp_pkg::HMTP_QDEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_text_byte,
  input  logic                                   in_stream_end,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_kind,
  output logic signed [hmtp_pkg::HMTP_VAL_W-1:0] out_value,
  output logic [hmtp_pkg::HMTP_COL_W-1:0]        out_column,
  output logic [hmtp_pkg::HMTP_ROW_W-1:0]        out_row,
  output logic                                   out_is_first_row
);
  import hmtp_pkg::*;

  `include "height_map_text_parser_macros.svh"

  hmtp_entry_t q_data, q_head;
  logic        q_push, q_pop, q_empty, q_full;

  hmtp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_stream_end (in_stream_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  hmtp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  hmtp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_is_first_row (out_is_first_row)
  );

  `HMTP_ASSERT_IMPL(a_row_end_zero, clk, rst_n, out_valid && (out_kind == KIND_ROW_END), out_value == '0, "row end beat with nonzero value")
  `HMTP_ASSERT_IMPL(a_field_col_limit, clk, rst_n, out_valid && (out_kind == KIND_FIELD), out_column < HMTP_COL_W'(HMTP_MAX_COLS), "field column beyond map width limit")
  `HMTP_ASSERT_NEXT(a_drain_queue, clk, rst_n, !q_empty && (!out_valid || out_ready), out_valid, "queued entry not moved to output")

endmodule

### src/hmtp_queue.sv
// ----------------------------------------------------------------------------
// Height map text parser queue
// Small FIFO of parsed entries between the byte parser and the beat emitter.
// ----------------------------------------------------------------------------
module hmtp_queue #(
  parameter int DEPTH = hmtp_pkg::HMTP_QDEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hmtp_pkg::hmtp_entry_t push_data,
  input  logic                pop,
  output hmtp_pkg::hmtp_entry_t head,
  output logic                empty,
  output logic                full
);
  import hmtp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hmtp_entry_t            mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/hmtp_front.sv
// ----------------------------------------------------------------------------
// Height map text parser front end
// Accepts one text byte per beat, tracks field and row state, and builds
// one queue entry holding the field and row-end results the byte causes.
// ----------------------------------------------------------------------------
module hmtp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_stream_end,
  input  logic                            q_full,
  output logic                            q_push,
  output hmtp_pkg::hmtp_entry_t           q_data
);
  import hmtp_pkg::*;

  typedef enum logic [4:0] {
    PH_GAP  = 5'b00001,
    PH_LEAD = 5'b00010,
    PH_DIG  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_DONE = 5'b10000
  } hmtp_phase_t;

  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_NL    = 8'd10;
  localparam logic [7:0] CHR_SP    = 8'd32;
  localparam logic [7:0] CHR_PLUS  = 8'd43;
  localparam logic [7:0] CHR_MINUS = 8'd45;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  hmtp_phase_t            phase_r, phase_nxt, ph1;
  logic [HMTP_VAL_W-1:0]  acc_r, acc_nxt, acc1, digit;
  logic                   neg_r, neg_nxt, neg1;
  logic [HMTP_COL_W-1:0]  col_cnt_r, col_cnt_nxt, cc1, limit;
  logic [HMTP_ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [HMTP_COL_W-1:0]  row_width_r, row_width_nxt;
  logic                   width_known_r, width_known_nxt;
  logic                   line_bytes_r, line_bytes_nxt, lhb1;
  logic                   accept, is_nl, is_sp, is_digit;
  logic                   close_a, end_a, blank_end, close_b, end_b;
  logic                   do_close, do_end, fld_emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_nl    = (in_text_byte == CHR_NL);
  assign is_sp    = (in_text_byte == CHR_SP);
  assign is_digit = (in_text_byte >= CHR_ZERO) && (in_text_byte <= CHR_NINE);
  assign digit    = {{(HMTP_VAL_W-4){1'b0}}, in_text_byte[3:0]};

  always_comb begin
    ph1       = phase_r;
    acc1      = acc_r;
    neg1      = neg_r;
    lhb1      = line_bytes_r;
    close_a   = 1'b0;
    end_a     = 1'b0;
    blank_end = 1'b0;
    if (phase_r != PH_DONE) begin
      if (is_nl) begin
        if (!line_bytes_r) begin
          blank_end = 1'b1;
        end else begin
          close_a = (phase_r != PH_GAP);
          end_a   = 1'b1;
        end
      end else begin
        lhb1 = 1'b1;
        if (is_sp) begin
          close_a = (phase_r != PH_GAP);
        end else begin
          case (phase_r)
            PH_GAP, PH_LEAD: begin
              if (phase_r == PH_GAP) begin
                acc1 = '0;
                neg1 = 1'b0;
              end
              if (in_text_byte == CHR_TAB) begin
                ph1 = PH_LEAD;
              end else if (in_text_byte == CHR_MINUS) begin
                neg1 = 1'b1;
                ph1  = PH_DIG;
              end else if (in_text_byte == CHR_PLUS) begin
                ph1 = PH_DIG;
              end else if (is_digit) begin
                acc1 = digit;
                ph1  = PH_DIG;
              end else begin
                ph1 = PH_SKIP;
              end
            end
            PH_DIG: begin
              if (is_digit) begin
                acc1 = (acc_r << 3) + (acc_r << 1) + digit;
              end else begin
                ph1 = PH_SKIP;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    end_b    = in_stream_end && !end_a && !blank_end && (phase_r != PH_DONE) && lhb1;
    close_b  = end_b && !close_a && (ph1 != PH_GAP);
    do_close = close_a || close_b;
    do_end   = end_a || end_b;
    limit    = width_known_r ? row_width_r : HMTP_COL_W'(HMTP_MAX_COLS);
    fld_emit = do_close && (col_cnt_r < limit);
    cc1      = col_cnt_r + {{(HMTP_COL_W-1){1'b0}}, fld_emit};
  end

  always_comb begin
    q_data.fld_v   = fld_emit;
    q_data.end_v   = do_end;
    q_data.value   = neg1 ? (~acc1 + 1'b1) : acc1;
    q_data.fld_col = col_cnt_r;
    q_data.end_col = cc1;
    q_data.row     = row_cnt_r;
    q_data.first   = !width_known_r;
    q_push         = accept && (fld_emit || do_end);
  end

  always_comb begin
    phase_nxt       = ph1;
    acc_nxt         = acc1;
    neg_nxt         = neg1;
    line_bytes_nxt  = lhb1;
    col_cnt_nxt     = col_cnt_r;
    row_cnt_nxt     = row_cnt_r;
    row_width_nxt   = row_width_r;
    width_known_nxt = width_known_r;
    if (blank_end) begin
      phase_nxt = PH_DONE;
    end
    if (do_close) begin
      col_cnt_nxt = cc1;
      acc_nxt     = '0;
      neg_nxt     = 1'b0;
      phase_nxt   = PH_GAP;
    end
    if (do_end) begin
      if (!width_known_r) begin
        row_width_nxt = cc1;
      end
      width_known_nxt = 1'b1;
      row_cnt_nxt     = row_cnt_r + 1'b1;
      col_cnt_nxt     = '0;
      line_bytes_nxt  = 1'b0;
      phase_nxt       = (row_cnt_r == HMTP_ROW_W'(HMTP_MAX_ROWS - 1)) ? PH_DONE : PH_GAP;
    end
    if (in_stream_end) begin
      phase_nxt       = PH_GAP;
      acc_nxt         = '0;
      neg_nxt         = 1'b0;
      line_bytes_nxt  = 1'b0;
      col_cnt_nxt     = '0;
      row_cnt_nxt     = '0;
      row_width_nxt   = '0;
      width_known_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_GAP;
      acc_r         <= '0;
      neg_r         <= 1'b0;
      col_cnt_r     <= '0;
      row_cnt_r     <= '0;
      row_width_r   <= '0;
      width_known_r <= 1'b0;
      line_bytes_r  <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      acc_r         <= acc_nxt;
      neg_r         <= neg_nxt;
      col_cnt_r     <= col_cnt_nxt;
      row_cnt_r     <= row_cnt_nxt;
      row_width_r   <= row_width_nxt;
      width_known_r <= width_known_nxt;
      line_bytes_r  <= line_bytes_nxt;
    end
  end

endmodule

### src/hmtp_back.sv
// ----------------------------------------------------------------------------
// Height map text parser back end
// Expands each queue entry into a field beat and/or a row-end beat and
// holds them in an output register until the receiver takes them.
// ----------------------------------------------------------------------------
module hmtp_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hmtp_pkg::hmtp_entry_t                 head,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_kind,
  output logic signed [hmtp_pkg::HMTP_VAL_W-1:0] out_value,
  output logic [hmtp_pkg::HMTP_COL_W-1:0]       out_column,
  output logic [hmtp_pkg::HMTP_ROW_W-1:0]       out_row,
  output logic                                  out_is_first_row
);
  import hmtp_pkg::*;

  logic                  valid_r, valid_nxt;
  logic                  fld_done_r, fld_done_nxt;
  logic                  load, emit_fld;
  logic                  kind_r;
  logic [HMTP_VAL_W-1:0] value_r;
  logic [HMTP_COL_W-1:0] column_r;
  logic [HMTP_ROW_W-1:0] row_r;
  logic                  first_r;

  assign load     = !q_empty && (!valid_r || out_ready);
  assign emit_fld = head.fld_v && !fld_done_r;
  assign q_pop    = load && !(emit_fld && head.end_v);

  always_comb begin
    valid_nxt    = valid_r;
    fld_done_nxt = fld_done_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt    = 1'b1;
      fld_done_nxt = emit_fld && head.end_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      fld_done_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      fld_done_r <= fld_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= emit_fld ? KIND_FIELD : KIND_ROW_END;
      value_r  <= emit_fld ? head.value : '0;
      column_r <= emit_fld ? head.fld_col : head.end_col;
      row_r    <= head.row;
      first_r  <= head.first;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_value        = value_r;
  assign out_column       = column_r;
  assign out_row          = row_r;
  assign out_is_first_row = first_r;

endmodule
